FILE: src/frl_pkg.sv
// ----------------------------------------------------------------------------
// frl_pkg: shared constants for the first-appearance relabeler
// Field widths of the request and result channels and parameter defaults.
// ----------------------------------------------------------------------------
package frl_pkg;

  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned LABEL_BITS = 5;

  localparam int unsigned LABEL_CAPACITY_DEF = 26;
  localparam int unsigned KEY_BITS_DEF       = 64;

endpackage

FILE: src/frl_in_if.sv
// ----------------------------------------------------------------------------
// frl_in_if: request channel of the relabeler
// One state value per request plus the end-of-vector mark.
// ----------------------------------------------------------------------------
interface frl_in_if
  import frl_pkg::*;
();

  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);

endinterface

FILE: src/frl_out_if.sv
// ----------------------------------------------------------------------------
// frl_out_if: result channel of the relabeler
// Dense label, overflow flag and end-of-vector mark for one request.
// ----------------------------------------------------------------------------
interface frl_out_if
  import frl_pkg::*;
();

  logic                  valid;
  logic                  ready;
  logic [LABEL_BITS-1:0] label;
  logic                  overflow;
  logic                  last_out;

  modport source (output valid, output label, output overflow, output last_out,
                  input ready);
  modport sink   (input valid, input label, input overflow, input last_out,
                  output ready);

endinterface

FILE: src/first_appearance_relabeler.sv
// ----------------------------------------------------------------------------
// first_appearance_relabeler: dense labels in order of first appearance
// Each new key of a vector gets the next label, repeats get their old one.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one state value per request (value, last_in). Only the low
//         KeyBits bits of value are compared.
//   out_o returns exactly one result per request, in order: label, overflow,
//         last_out.
//   A request passes through an input register, then the key table lookup
//   (parallel compare of all stored keys and a priority encoder) into the
//   result register. One request is taken every cycle unless in_i stalls;
//   the lookup of a request sees the table as left by the request before it.
//   A new key beyond LabelCapacity distinct keys is not stored; its label
//   saturates at LabelCapacity-1 with overflow set. The request that carries
//   last_in empties the table once its lookup is done.
//   Reset empties the table and drops both pipeline registers.
//   When out_o stalls, the result register holds and the input register
//   fills; in_i stalls only when both are occupied.
// ----------------------------------------------------------------------------
module first_appearance_relabeler
  import frl_pkg::*;
#(
  parameter int unsigned LabelCapacity = LABEL_CAPACITY_DEF,
  parameter int unsigned KeyBits       = KEY_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  frl_in_if.sink      in_i,
  frl_out_if.source   out_o
);

  localparam int unsigned IdxW = (LabelCapacity > 1) ? $clog2(LabelCapacity) : 1;
  localparam int unsigned CntW = $clog2(LabelCapacity + 1);
  localparam int unsigned LblW = (IdxW > LABEL_BITS) ? IdxW : LABEL_BITS;

  localparam logic [CntW-1:0] CapCnt  = CntW'(LabelCapacity);
  localparam logic [IdxW-1:0] SatIdx  = IdxW'(LabelCapacity - 1);
  localparam logic [LblW-1:0] SatWide = LblW'(SatIdx);

  // input register
  logic               s1_valid_q;
  logic [KeyBits-1:0] s1_key_q;
  logic               s1_last_q;

  // result register
  logic                  out_valid_q;
  logic [LABEL_BITS-1:0] out_label_q;
  logic                  out_ovf_q;
  logic                  out_last_q;

  // key table
  logic [KeyBits-1:0] keys_q [LabelCapacity];
  logic [CntW-1:0]    count_q, count_d;

  logic s1_fire;
  logic in_fire;

  logic [LabelCapacity-1:0] hit_vec;
  logic                     hit;
  logic [IdxW-1:0]          hit_idx;
  logic                     full;
  logic                     store;
  logic [IdxW-1:0]          lbl_idx;
  logic                     ovf_d;
  logic [LblW-1:0]          lbl_wide;

  assign s1_fire  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire  = in_i.valid && in_i.ready;

  // parallel compare against valid entries
  always_comb begin
    for (int unsigned i = 0; i < LabelCapacity; i++) begin
      hit_vec[i] = (count_q > CntW'(i)) && (keys_q[i] == s1_key_q);
    end
  end

  // lowest matching entry wins
  always_comb begin
    hit_idx = '0;
    for (int i = int'(LabelCapacity) - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IdxW'(i);
      end
    end
  end

  assign hit   = |hit_vec;
  assign full  = (count_q == CapCnt);
  assign store = s1_fire && !hit && !full;
  assign ovf_d = !hit && full;

  always_comb begin
    if (hit) begin
      lbl_idx = hit_idx;
    end else if (full) begin
      lbl_idx = SatIdx;
    end else begin
      lbl_idx = count_q[IdxW-1:0];
    end
  end

  assign lbl_wide = LblW'(lbl_idx);

  always_comb begin
    count_d = count_q;
    if (s1_fire) begin
      if (s1_last_q) begin
        count_d = '0;
      end else if (!hit && !full) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned i = 0; i < LabelCapacity; i++) begin
      if (store && (count_q == CntW'(i))) begin
        keys_q[i] <= s1_key_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      count_q <= count_d;
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (!out_valid_q || out_o.ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_key_q  <= in_i.value[KeyBits-1:0];
      s1_last_q <= in_i.last_in;
    end
    if (s1_fire) begin
      out_label_q <= lbl_wide[LABEL_BITS-1:0];
      out_ovf_q   <= ovf_d;
      out_last_q  <= s1_last_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.label    = out_label_q;
  assign out_o.overflow = out_ovf_q;
  assign out_o.last_out = out_last_q;

  // table fill never passes capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CapCnt)
    else $error("key table count above capacity");

  // the end-of-vector request empties the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_last_q |=> count_q == '0)
    else $error("table not emptied after last request");

  // an overflow result carries the saturated label
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ovf_q |-> out_label_q == SatWide[LABEL_BITS-1:0])
    else $error("overflow result without saturated label");

  // a stored key is counted unless its request ends the vector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    store && !s1_last_q |=> count_q != '0)
    else $error("stored key not counted");

endmodule

FILE: tb/sv/first_appearance_relabeler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_appearance_relabeler_tb: self-checking bench for the relabeler
// Drives vectors of 64-bit keys with random request gaps and result stalls.
// A scoreboard class keeps its own key table per vector, predicts label,
// overflow and last mark for every accepted request, and compares each
// result in order. Covers bitwise key equality, table overflow with label
// saturation, and table clearing at the end of each vector.
// ----------------------------------------------------------------------------
module first_appearance_relabeler_tb;
  import frl_pkg::*;

  localparam int unsigned RandomRequests = 1500;
  localparam int unsigned SteadyTail     = 200;
  localparam int unsigned IdleLimit      = 5000;

  typedef logic [VALUE_BITS-1:0] key_t;

  typedef struct packed {
    logic [LABEL_BITS-1:0] label;
    logic                  overflow;
    logic                  last_out;
  } relabel_result_t;

  class relabel_scoreboard;
    key_t            key_table[LABEL_CAPACITY_DEF];
    int unsigned     keys_held;
    relabel_result_t expected_labels[$];
    int unsigned     failures;

    function new();
      keys_held = 0;
      failures  = 0;
    endfunction

    // lowest matching slot wins; a new key takes the next slot if one is free
    function relabel_result_t assign_label(key_t value, logic last_in);
      key_t            key;
      key_t            key_mask;
      int unsigned     slot;
      bit              found;
      relabel_result_t res;
      key_mask = (KEY_BITS_DEF >= VALUE_BITS) ? '1 : ((key_t'(1) << KEY_BITS_DEF) - 1);
      key      = value & key_mask;
      found    = 1'b0;
      slot     = 0;
      for (int unsigned i = 0; i < keys_held; i++) begin
        if (!found && key_table[i] == key) begin
          found = 1'b1;
          slot  = i;
        end
      end
      res.overflow = 1'b0;
      if (!found) begin
        if (keys_held < LABEL_CAPACITY_DEF) begin
          key_table[keys_held] = key;
          slot                 = keys_held;
          keys_held++;
        end else begin
          slot         = LABEL_CAPACITY_DEF - 1;
          res.overflow = 1'b1;
        end
      end
      if (last_in) keys_held = 0;
      res.label    = slot[LABEL_BITS-1:0];
      res.last_out = last_in;
      return res;
    endfunction

    function void note_request(key_t value, logic last_in);
      expected_labels.push_back(assign_label(value, last_in));
    endfunction

    function void check_result(relabel_result_t got);
      relabel_result_t exp;
      if (expected_labels.size() == 0) begin
        $display("%0t: result with no request pending: expected none, actual label %0d",
                 $time, got.label);
        failures++;
        return;
      end
      exp = expected_labels.pop_front();
      if (got.label !== exp.label) begin
        $display("%0t: label mismatch: expected %0d, actual %0d",
                 $time, exp.label, got.label);
        failures++;
      end
      if (got.overflow !== exp.overflow) begin
        $display("%0t: overflow mismatch: expected %0b, actual %0b",
                 $time, exp.overflow, got.overflow);
        failures++;
      end
      if (got.last_out !== exp.last_out) begin
        $display("%0t: last_out mismatch: expected %0b, actual %0b",
                 $time, exp.last_out, got.last_out);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_labels.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  frl_in_if  req_if ();
  frl_out_if res_if ();

  first_appearance_relabeler uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if.sink),
    .out_o  (res_if.source)
  );

  relabel_scoreboard scoreboard = new();
  bit                steady_phase;
  int unsigned       requests_sent;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic key_t random_key();
    return {$urandom, $urandom};
  endfunction

  task automatic send_request(input key_t value, input logic last_in);
    int unsigned gap;
    if (!steady_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.value   <= value;
    req_if.last_in <= last_in;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    scoreboard.note_request(value, last_in);
    requests_sent++;
  endtask

  task automatic run_directed();
    key_t nan_key;
    nan_key = 64'h7ff8_0000_0000_0001;
    // zero and all ones, then signed zero and a repeated nan pattern
    send_request(64'h0, 1'b0);
    send_request('1, 1'b0);
    send_request(64'h0, 1'b0);
    send_request(64'h8000_0000_0000_0000, 1'b0);
    send_request(nan_key, 1'b0);
    send_request(nan_key, 1'b0);
    // fill the table to capacity
    for (int unsigned k = 4; k < LABEL_CAPACITY_DEF; k++)
      send_request(64'h0000_0001_0000_0000 + k, 1'b0);
    // table full: new key saturates, stored keys keep their labels
    send_request(64'h5555_5555_5555_5555, 1'b0);
    send_request('1, 1'b0);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    // one-element vector, then the same key opens the next one at label 0
    send_request(64'h0123_4567_89AB_CDEF, 1'b1);
    send_request(64'h0123_4567_89AB_CDEF, 1'b0);
    send_request(64'hFEDC_BA98_7654_3210, 1'b1);
  endtask

  task automatic run_random();
    key_t        pool[$];
    key_t        value;
    int unsigned pool_size;
    int unsigned vec_len;
    int unsigned start_count;
    logic        last_in;
    start_count = requests_sent;
    while (requests_sent - start_count < RandomRequests) begin
      steady_phase = (requests_sent - start_count) >= RandomRequests - SteadyTail;
      pool.delete();
      pool_size = $urandom_range(1, 34);
      for (int unsigned p = 0; p < pool_size; p++) begin
        case ($urandom_range(0, 7))
          0: pool.push_back(64'h0);
          1: pool.push_back('1);
          2: pool.push_back(pool.size() != 0 ?
                            pool[0] ^ (key_t'(1) << $urandom_range(0, VALUE_BITS - 1)) :
                            random_key());
          default: pool.push_back(random_key());
        endcase
      end
      vec_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 40);
      for (int unsigned n = 0; n < vec_len; n++) begin
        if ($urandom_range(0, 15) == 0) value = random_key();
        else value = pool[$urandom_range(0, pool_size - 1)];
        // a stray end mark now and then splits a vector early
        last_in = (n == vec_len - 1) || ($urandom_range(0, 39) == 0);
        send_request(value, last_in);
      end
    end
  endtask

  // result side: random stall bursts, none in the steady tail
  initial begin
    int unsigned stall_left;
    relabel_result_t got;
    stall_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        got.label    = res_if.label;
        got.overflow = res_if.overflow;
        got.last_out = res_if.last_out;
        scoreboard.check_result(got);
      end
      if (stall_left == 0 && !steady_phase && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 11);
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // ends the run if neither channel moves for too long
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no request or result moved for %0d cycles", $time, IdleLimit);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.value   = '0;
    req_if.last_in = 1'b0;
    steady_phase   = 1'b0;
    requests_sent  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    req_if.valid <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (scoreboard.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: first_appearance_relabeler.f
src/frl_pkg.sv
src/frl_in_if.sv
src/frl_out_if.sv
src/first_appearance_relabeler.sv
tb/sv/first_appearance_relabeler_tb.sv
